// ----- design/kthd_pkg.sv -----
// Shared constants for the keypad scanner and hex display block.
// Holds field widths, scanner mode codes, register indexes and the segment table.
// Used by the channel interfaces and by keypad_to_hex_display.
package kthd_pkg;

   localparam int COL_W   = 4;
   localparam int ROW_W   = 4;
   localparam int SEG_W   = 7;
   localparam int DIGEN_W = 4;
   localparam int KEY_W   = 4;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] MODE_SCAN     = 2'd0;
   localparam logic [1:0] MODE_DEBOUNCE = 2'd1;
   localparam logic [1:0] MODE_RELEASE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL    = 1'd1;

   localparam logic [CSR_W-1:0] DEBOUNCE_RESET = 16'd51968;
   localparam logic [CSR_W-1:0] DWELL_RESET    = 16'd2816;

   // Active-low segment pattern for one hex digit, bit 0 is segment a.
   function automatic logic [SEG_W-1:0] seg_pattern(input logic [KEY_W-1:0] digit);
      logic [SEG_W-1:0] pat;
      case (digit)
         4'h0: pat = 7'h40;
         4'h1: pat = 7'h79;
         4'h2: pat = 7'h24;
         4'h3: pat = 7'h30;
         4'h4: pat = 7'h19;
         4'h5: pat = 7'h12;
         4'h6: pat = 7'h02;
         4'h7: pat = 7'h78;
         4'h8: pat = 7'h00;
         4'h9: pat = 7'h10;
         4'ha: pat = 7'h08;
         4'hb: pat = 7'h03;
         4'hc: pat = 7'h46;
         4'hd: pat = 7'h21;
         4'he: pat = 7'h06;
         4'hf: pat = 7'h0E;
         default: pat = 7'h7F;
      endcase
      return pat;
   endfunction

endpackage

// ----- design/kthd_req_if.sv -----
// Input channel of the keypad scanner: one column sample per word.
// Depends on kthd_pkg for the field width.
interface kthd_req_if;
   logic                        valid;
   logic                        ready;
   logic [kthd_pkg::COL_W-1:0]  col_sense_n;

   modport source (output valid, output col_sense_n, input ready);
   modport sink   (input valid, input col_sense_n, output ready);
endinterface

// ----- design/kthd_rsp_if.sv -----
// Result channel of the keypad scanner: drive lines, display lines and key report.
// Depends on kthd_pkg for the field widths.
interface kthd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kthd_pkg::ROW_W-1:0]    row_drive_n;
   logic [kthd_pkg::SEG_W-1:0]    segments_n;
   logic [kthd_pkg::DIGEN_W-1:0]  digit_enable_n;
   logic                          key_valid;
   logic [kthd_pkg::KEY_W-1:0]    key_code;

   modport source (output valid, output row_drive_n, output segments_n,
                   output digit_enable_n, output key_valid, output key_code,
                   input ready);
   modport sink   (input valid, input row_drive_n, input segments_n,
                   input digit_enable_n, input key_valid, input key_code,
                   output ready);
endinterface

// ----- design/keypad_to_hex_display.sv -----
// Keypad scanner with a multiplexed hex seven-segment display.
// Each result word is registered: it appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while results are taken; the output register frees as it is taken.
// Reset (synchronous, active high) loads digits 1,2,3,4, row and column 0,
// scanning mode, both counters zero and the register reset values.
// Depends on kthd_pkg, kthd_req_if and kthd_rsp_if.
module keypad_to_hex_display #(
   parameter int NUM_DIGITS  = 4,
   parameter int KEYPAD_SIDE = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   kthd_req_if.sink                           req_if,
   kthd_rsp_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [kthd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kthd_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int SideW  = $clog2(KEYPAD_SIDE);
   localparam int DigW   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [SideW:0]  SideCnt = (SideW + 1)'(KEYPAD_SIDE);
   localparam logic [kthd_pkg::KEY_W-1:0] SideKey = kthd_pkg::KEY_W'(KEYPAD_SIDE);
   localparam logic [DigW-1:0] LastDigit = DigW'(NUM_DIGITS - 1);

   logic [kthd_pkg::CSR_W-1:0]  debounce_ticks_ff, dwell_ticks_ff;

   logic [kthd_pkg::KEY_W-1:0]  digit_ff [NUM_DIGITS];
   logic [kthd_pkg::KEY_W-1:0]  digit_in [NUM_DIGITS];
   logic [SideW-1:0]            row_ff, row_in;
   logic [SideW-1:0]            next_col_ff, next_col_in;
   logic [1:0]                  mode_ff, mode_in;
   logic [SideW-1:0]            held_col_ff, held_col_in;
   logic [kthd_pkg::CSR_W-1:0]  debounce_cnt_ff, debounce_cnt_in;
   logic [DigW-1:0]             shown_ff, shown_in;
   logic [kthd_pkg::CSR_W-1:0]  dwell_cnt_ff, dwell_cnt_in;

   logic                              rsp_valid_ff;
   logic [kthd_pkg::ROW_W-1:0]        row_drive_ff, row_drive_in;
   logic [kthd_pkg::SEG_W-1:0]        segments_ff, segments_in;
   logic [kthd_pkg::DIGEN_W-1:0]      digit_en_ff, digit_en_in;
   logic                              key_valid_ff, key_valid_in;
   logic [kthd_pkg::KEY_W-1:0]        key_code_ff, key_code_in;

   logic                        accept;
   logic [KEYPAD_SIDE-1:0]      pressed;
   logic                        key_found;
   logic [SideW-1:0]            found_col;
   logic [kthd_pkg::CSR_W-1:0]  dwell_eff;
   logic [kthd_pkg::CSR_W:0]    dwell_next;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign pressed      = ~req_if.col_sense_n[KEYPAD_SIDE-1:0];

   // Lowest pressed column at or after the resume position.
   always_comb begin
      key_found = 1'b0;
      found_col = '0;
      for (int c = 0; c < KEYPAD_SIDE; c++) begin
         if (!key_found && pressed[c] && (SideW'(c) >= next_col_ff)) begin
            key_found = 1'b1;
            found_col = SideW'(c);
         end
      end
   end

   always_comb begin
      row_drive_in = '1;
      row_drive_in[row_ff] = 1'b0;
      segments_in = kthd_pkg::seg_pattern(digit_ff[shown_ff]);
      // The oldest digit sits on the highest enable line.
      for (int b = 0; b < kthd_pkg::DIGEN_W; b++) begin
         digit_en_in[b] = !(int'(shown_ff) == NUM_DIGITS - 1 - b);
      end
   end

   always_comb begin
      digit_in        = digit_ff;
      row_in          = row_ff;
      next_col_in     = next_col_ff;
      mode_in         = mode_ff;
      held_col_in     = held_col_ff;
      debounce_cnt_in = debounce_cnt_ff;
      key_valid_in    = 1'b0;
      key_code_in     = '0;
      case (mode_ff)
         kthd_pkg::MODE_DEBOUNCE: begin
            if (debounce_cnt_ff <= 16'd1) begin
               debounce_cnt_in = '0;
               mode_in         = kthd_pkg::MODE_RELEASE;
            end else begin
               debounce_cnt_in = debounce_cnt_ff - 16'd1;
            end
         end
         kthd_pkg::MODE_RELEASE: begin
            if (!pressed[held_col_ff]) begin
               mode_in = kthd_pkg::MODE_SCAN;
               if (({1'b0, held_col_ff} + (SideW + 1)'(1)) >= SideCnt) begin
                  row_in      = (row_ff == SideW'(KEYPAD_SIDE - 1)) ? '0 : row_ff + SideW'(1);
                  next_col_in = '0;
               end else begin
                  next_col_in = held_col_ff + SideW'(1);
               end
            end
         end
         default: begin
            if (key_found) begin
               key_valid_in = 1'b1;
               key_code_in  = kthd_pkg::KEY_W'(row_ff) * SideKey +
                              kthd_pkg::KEY_W'(found_col);
               for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                  digit_in[i] = digit_ff[i+1];
               end
               digit_in[NUM_DIGITS-1] = key_code_in;
               held_col_in     = found_col;
               debounce_cnt_in = (debounce_ticks_ff == '0) ? 16'd1 : debounce_ticks_ff;
               mode_in         = kthd_pkg::MODE_DEBOUNCE;
            end else begin
               mode_in     = kthd_pkg::MODE_SCAN;
               row_in      = (row_ff == SideW'(KEYPAD_SIDE - 1)) ? '0 : row_ff + SideW'(1);
               next_col_in = '0;
            end
         end
      endcase
   end

   // Digit multiplex timer runs independently of the scanner mode, but advances only on accepted words.
   always_comb begin
      dwell_eff  = (dwell_ticks_ff == '0) ? 16'd1 : dwell_ticks_ff;
      dwell_next = {1'b0, dwell_cnt_ff} + 17'd1;
      if (dwell_next >= {1'b0, dwell_eff}) begin
         dwell_cnt_in = '0;
         shown_in     = (shown_ff == LastDigit) ? '0 : shown_ff + DigW'(1);
      end else begin
         dwell_cnt_in = dwell_next[kthd_pkg::CSR_W-1:0];
         shown_in     = shown_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= kthd_pkg::DEBOUNCE_RESET;
         dwell_ticks_ff    <= kthd_pkg::DWELL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            kthd_pkg::CSR_DEBOUNCE: debounce_ticks_ff <= csr_wdata;
            kthd_pkg::CSR_DWELL:    dwell_ticks_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_ff[i] <= kthd_pkg::KEY_W'(i + 1);
         end
         row_ff          <= '0;
         next_col_ff     <= '0;
         mode_ff         <= kthd_pkg::MODE_SCAN;
         held_col_ff     <= '0;
         debounce_cnt_ff <= '0;
         shown_ff        <= '0;
         dwell_cnt_ff    <= '0;
      end else if (accept) begin
         digit_ff        <= digit_in;
         row_ff          <= row_in;
         next_col_ff     <= next_col_in;
         mode_ff         <= mode_in;
         held_col_ff     <= held_col_in;
         debounce_cnt_ff <= debounce_cnt_in;
         shown_ff        <= shown_in;
         dwell_cnt_ff    <= dwell_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_drive_ff <= row_drive_in;
         segments_ff  <= segments_in;
         digit_en_ff  <= digit_en_in;
         key_valid_ff <= key_valid_in;
         key_code_ff  <= key_code_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.row_drive_n    = row_drive_ff;
   assign rsp_if.segments_n     = segments_ff;
   assign rsp_if.digit_enable_n = digit_en_ff;
   assign rsp_if.key_valid      = key_valid_ff;
   assign rsp_if.key_code       = key_code_ff;

`ifndef ASSERT_OFF
   // A key taken while scanning must start the debounce wait.
   a_key_starts_debounce: assert property (@(posedge clock) disable iff (reset)
      accept && key_found && (mode_ff != kthd_pkg::MODE_DEBOUNCE) &&
      (mode_ff != kthd_pkg::MODE_RELEASE) |=> mode_ff == kthd_pkg::MODE_DEBOUNCE)
      else $error("key accepted without entering debounce");

   // The last debounce tick hands over to the release wait.
   a_debounce_ends: assert property (@(posedge clock) disable iff (reset)
      accept && (mode_ff == kthd_pkg::MODE_DEBOUNCE) && (debounce_cnt_ff <= 16'd1)
      |=> mode_ff == kthd_pkg::MODE_RELEASE)
      else $error("debounce did not end in release wait");

   // Exactly one keypad row is driven in every result word.
   a_one_row_driven: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> $countones(~rsp_if.row_drive_n) == 1)
      else $error("row drive is not a single active line");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for keypad_to_hex_display: drives column samples from a simulated
// keypad, predicts every output word and checks it at the result handshake.
// Depends on kthd_pkg, kthd_req_if, kthd_rsp_if and the keypad_to_hex_display RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;

   localparam logic [kthd_pkg::SEG_W-1:0] DIGIT_GLYPHS [16] = '{
      7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78,
      7'h00, 7'h10, 7'h08, 7'h03, 7'h46, 7'h21, 7'h06, 7'h0E
   };

   typedef struct packed {
      logic [3:0][3:0] digits;      // index 0 is the oldest digit
      logic [1:0]      row;
      logic [1:0]      next_col;
      logic [1:0]      mode;
      logic [1:0]      held_col;
      logic [15:0]     debounce_cnt;
      logic [1:0]      shown;
      logic [15:0]     dwell_cnt;
   } scanner_state_type;

   typedef struct packed {
      logic [kthd_pkg::ROW_W-1:0]   row_drive_n;
      logic [kthd_pkg::SEG_W-1:0]   segments_n;
      logic [kthd_pkg::DIGEN_W-1:0] digit_enable_n;
      logic                         key_valid;
      logic [kthd_pkg::KEY_W-1:0]   key_code;
   } scanner_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_we;
   logic [kthd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [kthd_pkg::CSR_W-1:0]     csr_wdata;

   kthd_req_if req_bus ();
   kthd_rsp_if rsp_bus ();

   keypad_to_hex_display dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [kthd_pkg::COL_W-1:0] column_samples [$];
   scanner_out_type   awaited_outputs [$];
   scanner_out_type   head_output;
   scanner_state_type scanner_view;   // state behind the checked outputs
   scanner_state_type stim_view;      // state that the stimulus generator tracks
   logic [15:0]      debounce_cfg = kthd_pkg::DEBOUNCE_RESET;
   logic [15:0]      dwell_cfg    = kthd_pkg::DWELL_RESET;
   int               src_idle_pct   = 0;
   int               sink_stall_pct = 0;
   int               fail_count     = 0;
   int               live_items     = 0;
   int               cycles         = 0;

   always #5 clock = ~clock;

   function automatic scanner_state_type power_on_state();
      scanner_state_type s;
      s = '0;
      s.digits[0] = 4'd1;
      s.digits[1] = 4'd2;
      s.digits[2] = 4'd3;
      s.digits[3] = 4'd4;
      s.mode      = kthd_pkg::MODE_SCAN;
      return s;
   endfunction

   // One scanner tick: the display and row lines reflect the state on entry.
   function automatic scanner_out_type keypad_tick(inout scanner_state_type s,
                                                  input logic [15:0] deb,
                                                  input logic [15:0] dwl,
                                                  input logic [kthd_pkg::COL_W-1:0] col_n);
      scanner_out_type r;
      logic [3:0]   pressed;
      logic [16:0]  dwell_len;
      logic [1:0]   sd;
      logic [1:0]   hit;
      bit           found;
      int           c;
      int           i;
      pressed   = ~col_n;
      dwell_len = (dwl == 16'd0) ? 17'd1 : {1'b0, dwl};
      sd        = s.shown;
      found     = 1'b0;
      hit       = 2'd0;
      r         = '0;
      r.row_drive_n    = ~(4'b0001 << s.row);
      r.segments_n     = DIGIT_GLYPHS[s.digits[sd]];
      r.digit_enable_n = ~(4'b0001 << (2'd3 - sd));
      case (s.mode)
         kthd_pkg::MODE_DEBOUNCE: begin
            if (s.debounce_cnt <= 16'd1) begin
               s.debounce_cnt = '0;
               s.mode         = kthd_pkg::MODE_RELEASE;
            end else begin
               s.debounce_cnt = s.debounce_cnt - 16'd1;
            end
         end
         kthd_pkg::MODE_RELEASE: begin
            if (!pressed[s.held_col]) begin
               s.mode = kthd_pkg::MODE_SCAN;
               if (s.held_col == 2'd3) begin
                  s.row      = s.row + 2'd1;
                  s.next_col = 2'd0;
               end else begin
                  s.next_col = s.held_col + 2'd1;
               end
            end
         end
         default: begin
            // Any code other than debounce or release behaves as scanning.
            for (c = int'(s.next_col); c < 4; c++) begin
               if (!found && pressed[c]) begin
                  found = 1'b1;
                  hit   = c[1:0];
               end
            end
            if (found) begin
               r.key_valid = 1'b1;
               r.key_code  = {s.row, hit};
               for (i = 0; i < 3; i++) s.digits[i] = s.digits[i+1];
               s.digits[3]    = {s.row, hit};
               s.held_col     = hit;
               s.debounce_cnt = (deb == 16'd0) ? 16'd1 : deb;
               s.mode         = kthd_pkg::MODE_DEBOUNCE;
            end else begin
               s.mode     = kthd_pkg::MODE_SCAN;
               s.row      = s.row + 2'd1;
               s.next_col = 2'd0;
            end
         end
      endcase
      if ({1'b0, s.dwell_cnt} + 17'd1 >= dwell_len) begin
         s.dwell_cnt = '0;
         s.shown     = sd + 2'd1;
      end else begin
         s.dwell_cnt = s.dwell_cnt + 16'd1;
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Queue one column sample and advance the generator's copy of the scanner.
   task automatic emit(input logic [kthd_pkg::COL_W-1:0] col_n);
      live_items++;
      column_samples.push_back(col_n);
      void'(keypad_tick(stim_view, debounce_cfg, dwell_cfg, col_n));
   endtask

   // Present the given keys for a number of ticks; noise flips column bits as bounce would.
   task automatic hold_keys(input logic [15:0] down, input int ticks, input int noise_pct);
      logic [kthd_pkg::COL_W-1:0] col_n;
      repeat (ticks) begin
         col_n = ~down[int'(stim_view.row)*4 +: 4];
         if ($urandom_range(99) < noise_pct) col_n = col_n ^ 4'($urandom_range(15));
         emit(col_n);
      end
   endtask

   function automatic int debounce_span();
      return (debounce_cfg == 16'd0) ? 1 : int'(debounce_cfg);
   endfunction

   task automatic tap_key(input logic [15:0] down, input int noise_pct);
      hold_keys(down, 4 + debounce_span() + $urandom_range(1, 6), noise_pct);
      hold_keys(16'h0000, $urandom_range(1, 5), 0);
   endtask

   task automatic wait_drained();
      while (!(column_samples.size() == 0 && !req_bus.valid && awaited_outputs.size() == 0))
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csrs(input logic [15:0] deb, input logic [15:0] dwl);
      wait_drained();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= kthd_pkg::CSR_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      csr_index <= kthd_pkg::CSR_DWELL;
      csr_wdata <= dwl;
      @(posedge clock);
      csr_we <= 1'b0;
      debounce_cfg = deb;
      dwell_cfg    = dwl;
   endtask

   task automatic run_phase(input logic [15:0] deb, input logic [15:0] dwl,
                            input int src_pct, input int sink_pct, input int target);
      int pick;
      logic [15:0] mask;
      write_csrs(deb, dwl);
      src_idle_pct   = src_pct;
      sink_stall_pct = sink_pct;
      live_items     = 0;
      while (live_items < target) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            tap_key(16'h0001 << $urandom_range(15), 5);
         end else if (pick < 80) begin
            mask = 16'($urandom_range(16'hFFFF)) & 16'($urandom_range(16'hFFFF));
            if (mask == 16'h0000) mask = 16'h8000;
            hold_keys(mask, 8 + 2 * debounce_span(), 5);
            hold_keys(mask & 16'($urandom_range(16'hFFFF)), 8 + debounce_span(), 5);
            hold_keys(16'h0000, 3, 0);
         end else begin
            repeat ($urandom_range(1, 8)) emit(4'($urandom_range(15)));
         end
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Column sample driver: a word stays on the bus until the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (column_samples.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
            req_bus.valid       <= 1'b1;
            req_bus.col_sense_n <= column_samples.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Output monitor: results are checked before the word accepted at the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_outputs.size() == 0) begin
               $error("result word arrived with nothing outstanding");
               fail_count++;
            end else begin
               head_output = awaited_outputs.pop_front();
               check_field("row_drive_n", 16'(head_output.row_drive_n), 16'(rsp_bus.row_drive_n));
               check_field("segments_n", 16'(head_output.segments_n), 16'(rsp_bus.segments_n));
               check_field("digit_enable_n", 16'(head_output.digit_enable_n),
                           16'(rsp_bus.digit_enable_n));
               check_field("key_valid", 16'(head_output.key_valid), 16'(rsp_bus.key_valid));
               check_field("key_code", 16'(head_output.key_code), 16'(rsp_bus.key_code));
            end
         end
         if (req_bus.valid && req_bus.ready)
            awaited_outputs.push_back(keypad_tick(scanner_view, debounce_cfg, dwell_cfg,
                                                  req_bus.col_sense_n));
      end
   end

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.col_sense_n = 4'hF;
      rsp_bus.ready       = 1'b0;
      csr_we              = 1'b0;
      csr_index           = kthd_pkg::CSR_DEBOUNCE;
      csr_wdata           = '0;
      scanner_view        = power_on_state();
      stim_view           = power_on_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: no key pressed, so the rows rotate and the reset digits show.
      repeat (6) emit(4'hF);

      // Directed words with the shortest debounce and dwell.
      write_csrs(16'd1, 16'd1);
      tap_key(16'h0001, 0);                    // lowest key
      tap_key(16'h8000, 0);                    // last column, scan wraps to the next row
      hold_keys(16'h0F00, 8, 0);               // every column of a row low at once
      hold_keys(16'h0000, 3, 0);
      hold_keys(16'h0060, 8, 0);               // two keys: the later column is found next
      hold_keys(16'h0040, 8, 0);
      hold_keys(16'h0000, 3, 0);

      // Zero in both registers acts as one.
      run_phase(16'd0, 16'd0, 67, 0, 130);
      run_phase(16'd3, 16'd5, 0, 67, 130);
      run_phase(16'd2, 16'd7, 25, 25, 130);
      run_phase(16'd4, 16'd3, 0, 0, 130);
      run_phase(16'd5, 16'd2, 25, 25, 130);

      // Largest settings: a press enters the long debounce wait and the dwell count climbs.
      write_csrs(16'hFFFF, 16'hFFFF);
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      hold_keys(16'h0200, 40, 30);
      hold_keys(16'h0000, 6, 0);

      wait_drained();
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
